/* design/dcs_pkg.sv */
// Shared types and widths for the distance constraint solver
package dcs_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned RestW   = 31;
  localparam int unsigned DiffW   = 33;
  localparam int unsigned SqW     = 66;
  localparam int unsigned RemW    = 68;
  localparam int unsigned RootW   = 34;
  localparam int unsigned DeltaW  = 36;
  localparam int unsigned MagW    = 35;
  localparam int unsigned DenW    = 35;
  localparam int unsigned NumW    = 69;
  localparam int unsigned QuotW   = 36;
  localparam int unsigned InW     = 168;
  localparam int unsigned OutW    = 136;

  localparam int unsigned SqrtCells = RootW;
  localparam int unsigned DivCells  = QuotW;
  localparam int unsigned SqrtFirst = 4;
  localparam int unsigned PostStage = SqrtFirst + SqrtCells;
  localparam int unsigned DivFirst  = PostStage + 3;
  localparam int unsigned LastStage = DivFirst + DivCells - 1;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic                     pa;
    logic                     pb;
    logic [RestW-1:0]         rest;
    logic [DiffW-1:0]         ux;
    logic [DiffW-1:0]         uy;
    logic                     same;
    logic                     sx;
    logic                     sy;
    logic                     sdel;
  } side_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [NumW-1:0]  rem_x;
    logic [NumW-1:0]  rem_y;
    logic [QuotW-1:0] q_x;
    logic [QuotW-1:0] q_y;
    logic [DenW-1:0]  den;
  } div_t;

endpackage

/* design/dcs_sqrt_cell.sv */
// One root bit of the pipelined integer square root
module dcs_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic           clk,
  input  logic           en,
  input  dcs_pkg::sqrt_t din,
  output dcs_pkg::sqrt_t dout
);

  logic [dcs_pkg::RemW:0] trial;
  logic                   fits;

  always_comb begin
    trial = ({{(dcs_pkg::RemW + 1 - dcs_pkg::RootW){1'b0}}, din.root} << (BIT + 1))
          + ({{dcs_pkg::RemW{1'b0}}, 1'b1} << (2 * BIT));
    fits  = trial <= {1'b0, din.rem};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem  <= fits ? din.rem - trial[dcs_pkg::RemW-1:0] : din.rem;
      dout.root <= fits ? din.root | (dcs_pkg::RootW'(1) << BIT) : din.root;
    end
  end

endmodule

/* design/dcs_div_cell.sv */
// One quotient bit of the pipelined two-axis restoring divider
module dcs_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  dcs_pkg::div_t din,
  output dcs_pkg::div_t dout
);

  localparam int unsigned CmpW = dcs_pkg::NumW + 2;

  logic [CmpW-1:0] dsh;
  logic            gex;
  logic            gey;

  always_comb begin
    dsh = {{(CmpW - dcs_pkg::DenW){1'b0}}, din.den} << SHIFT;
    gex = {2'b0, din.rem_x} >= dsh;
    gey = {2'b0, din.rem_y} >= dsh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem_x <= gex ? din.rem_x - dsh[dcs_pkg::NumW-1:0] : din.rem_x;
      dout.rem_y <= gey ? din.rem_y - dsh[dcs_pkg::NumW-1:0] : din.rem_y;
      dout.q_x   <= {din.q_x[dcs_pkg::QuotW-2:0], gex};
      dout.q_y   <= {din.q_y[dcs_pkg::QuotW-2:0], gey};
      dout.den   <= din.den;
    end
  end

endmodule

/* design/distance_constraint_solver.sv */
// Top level of the distance constraint solver
// One constraint per cycle enters and one result per cycle leaves while the output is not stalled; each
// item passes from acceptance to its result through the 34-cell square-root chain and the 36-cell divider
// chain plus eight stages of difference, squaring, delta and rounding. The whole pipeline holds
// only while a finished result waits at the output and the sink is not ready.
module distance_constraint_solver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // first_x, first_y, second_x, second_y, first_pinned, second_pinned, rest_length, zero pad
  input  logic [dcs_pkg::InW-1:0]    s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // new_first_x, new_first_y, new_second_x, new_second_y, coincident, clipped, zero pad
  output logic [dcs_pkg::OutW-1:0]   m_tdata
);

  localparam int unsigned Depth = dcs_pkg::LastStage + 1;
  localparam int unsigned SumW  = 38;

  logic                        en;
  logic [Depth-1:0]            vld;
  dcs_pkg::side_t              side [Depth];
  dcs_pkg::side_t              side_in;
  dcs_pkg::side_t              side1_next;
  dcs_pkg::side_t              post_next;
  logic signed [dcs_pkg::DiffW-1:0] dx;
  logic signed [dcs_pkg::DiffW-1:0] dy;
  logic [dcs_pkg::SqW-1:0]     sqx;
  logic [dcs_pkg::SqW-1:0]     sqy;
  dcs_pkg::sqrt_t              sq [dcs_pkg::SqrtCells+1];
  logic signed [dcs_pkg::DeltaW-1:0] delta;
  logic [dcs_pkg::MagW-1:0]    am;
  logic [dcs_pkg::MagW-1:0]    am_q;
  logic [dcs_pkg::DenW-1:0]    den;
  logic [dcs_pkg::DiffW-1:0]   adx;
  logic [dcs_pkg::DiffW-1:0]   ady;
  logic [dcs_pkg::DenW-1:0]    den_m;
  logic [dcs_pkg::DenW-1:0]    den_p;
  logic [50:0]                 plx;
  logic [49:0]                 phx;
  logic [50:0]                 ply;
  logic [49:0]                 phy;
  dcs_pkg::div_t               dv [dcs_pkg::DivCells+1];
  logic signed [SumW-1:0]      mvx;
  logic signed [SumW-1:0]      mvy;
  logic signed [SumW-1:0]      nax;
  logic signed [SumW-1:0]      nay;
  logic signed [SumW-1:0]      nbx;
  logic signed [SumW-1:0]      nby;
  logic [3:0]                  clipv;
  dcs_pkg::side_t              sl;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[Depth-2:0], s_tvalid};
      m_tvalid <= vld[Depth-1];
    end
  end

  always_comb begin
    side_in      = '0;
    side_in.ax   = s_tdata[31:0];
    side_in.ay   = s_tdata[63:32];
    side_in.bx   = s_tdata[95:64];
    side_in.by   = s_tdata[127:96];
    side_in.pa   = s_tdata[128];
    side_in.pb   = s_tdata[129];
    side_in.rest = s_tdata[160:130];
  end

  always_comb begin
    dx = {side[0].ax[31], side[0].ax} - {side[0].bx[31], side[0].bx};
    dy = {side[0].ay[31], side[0].ay} - {side[0].by[31], side[0].by};
    side1_next      = side[0];
    side1_next.ux   = dx[dcs_pkg::DiffW-1] ? dcs_pkg::DiffW'(-dx) : dcs_pkg::DiffW'(dx);
    side1_next.uy   = dy[dcs_pkg::DiffW-1] ? dcs_pkg::DiffW'(-dy) : dcs_pkg::DiffW'(dy);
    side1_next.sx   = dx[dcs_pkg::DiffW-1];
    side1_next.sy   = dy[dcs_pkg::DiffW-1];
    side1_next.same = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      side[1] <= side1_next;
      for (int k = 2; k < int'(Depth); k++) begin
        side[k] <= (k == int'(dcs_pkg::PostStage)) ? post_next : side[k-1];
      end
      sqx <= side[1].ux * side[1].ux;
      sqy <= side[1].uy * side[1].uy;
      sq[0].rem  <= {2'b0, sqx} + {2'b0, sqy};
      sq[0].root <= '0;
    end
  end

  for (genvar k = 0; k < dcs_pkg::SqrtCells; k++) begin : g_sqrt
    dcs_sqrt_cell #(.BIT(dcs_pkg::SqrtCells - 1 - k)) u_cell (
      .clk  (clk),
      .en   (en),
      .din  (sq[k]),
      .dout (sq[k+1])
    );
  end

  always_comb begin
    sl    = side[dcs_pkg::PostStage-1];
    delta = {{(dcs_pkg::DeltaW - dcs_pkg::RestW){1'b0}}, sl.rest}
          - {{(dcs_pkg::DeltaW - dcs_pkg::RootW){1'b0}}, sq[dcs_pkg::SqrtCells].root};
    am    = delta[dcs_pkg::DeltaW-1] ? dcs_pkg::MagW'(-delta) : dcs_pkg::MagW'(delta);
    den   = (sl.pa || sl.pb) ? {1'b0, sq[dcs_pkg::SqrtCells].root}
                             : {sq[dcs_pkg::SqrtCells].root, 1'b0};
    post_next      = sl;
    post_next.sdel = delta[dcs_pkg::DeltaW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx   <= sl.ux;
      ady   <= sl.uy;
      den_m <= den;
      plx   <= adx * 51'(am_q[17:0]);
      phx   <= adx * 50'(am_q[34:18]);
      ply   <= ady * 51'(am_q[17:0]);
      phy   <= ady * 50'(am_q[34:18]);
      den_p <= den_m;
      dv[0].rem_x <= {18'b0, plx} + ({19'b0, phx} << 18) + {35'b0, den_p[34:1]};
      dv[0].rem_y <= {18'b0, ply} + ({19'b0, phy} << 18) + {35'b0, den_p[34:1]};
      dv[0].q_x   <= '0;
      dv[0].q_y   <= '0;
      dv[0].den   <= den_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_q <= am;
    end
  end

  for (genvar k = 0; k < dcs_pkg::DivCells; k++) begin : g_div
    dcs_div_cell #(.SHIFT(dcs_pkg::DivCells - 1 - k)) u_cell (
      .clk  (clk),
      .en   (en),
      .din  (dv[k]),
      .dout (dv[k+1])
    );
  end

  always_comb begin
    mvx = {2'b0, dv[dcs_pkg::DivCells].q_x};
    mvy = {2'b0, dv[dcs_pkg::DivCells].q_y};
    if (side[Depth-1].sx != side[Depth-1].sdel) mvx = -mvx;
    if (side[Depth-1].sy != side[Depth-1].sdel) mvy = -mvy;
    nax = SumW'(side[Depth-1].ax);
    nay = SumW'(side[Depth-1].ay);
    nbx = SumW'(side[Depth-1].bx);
    nby = SumW'(side[Depth-1].by);
    if (!side[Depth-1].same && !side[Depth-1].pa) begin
      nax = nax + mvx;
      nay = nay + mvy;
    end
    if (!side[Depth-1].same && !side[Depth-1].pb) begin
      nbx = nbx - mvx;
      nby = nby - mvy;
    end
    clipv[0] = nax > SumW'(32'sh7fffffff) || nax < -SumW'(64'sh80000000);
    clipv[1] = nay > SumW'(32'sh7fffffff) || nay < -SumW'(64'sh80000000);
    clipv[2] = nbx > SumW'(32'sh7fffffff) || nbx < -SumW'(64'sh80000000);
    clipv[3] = nby > SumW'(32'sh7fffffff) || nby < -SumW'(64'sh80000000);
  end

  function automatic logic [31:0] sat(input logic signed [SumW-1:0] v, input logic c);
    logic [31:0] r;
    r = v[31:0];
    if (c) r = v[SumW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata[31:0]    <= sat(nax, clipv[0]);
      m_tdata[63:32]   <= sat(nay, clipv[1]);
      m_tdata[95:64]   <= sat(nbx, clipv[2]);
      m_tdata[127:96]  <= sat(nby, clipv[3]);
      m_tdata[128]     <= side[Depth-1].same;
      m_tdata[129]     <= |clipv;
      m_tdata[135:130] <= '0;
    end
  end

endmodule

/* design/dcs_checker.sv */
// Port checker for the distance constraint solver, bound to the top level
module dcs_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [dcs_pkg::OutW-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result shown after reset");

  a_same: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[128] |-> m_tdata[63:0] == m_tdata[127:64] && !m_tdata[129])
    else $error("coincident result moved a point");

endmodule

bind distance_constraint_solver dcs_checker u_dcs_checker (.*);
